@@ hdl/dwsp_pkg.sv @@
// ----------------------------------------------------------------------------
// dwsp_pkg
// Shared types, widths, register indexes and reset values for the dual wheel
// speed controller.
// ----------------------------------------------------------------------------
package dwsp_pkg;

    // default parameter values
    localparam int PWM_TOP_DEF   = 999;
    localparam int FRAC_BITS_DEF = 8;

    // field widths
    localparam int COUNT_W      = 32;
    localparam int SP_W         = 16;
    localparam int SPEED_W      = 24;
    localparam int DUTY_W       = 10;
    localparam int GAIN_W       = 16;
    localparam int SCALE_W      = 10;
    localparam int RATE_SCALE_W = 12;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    // shared multiplier widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = MUL_P_W + 2;

    // opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_STOP = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_INT_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_PROP_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_INT_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_SPEED_SCALE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_RATE_SCALE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DRIVE        = 3'd7;

    // register reset values
    localparam logic [GAIN_W-1:0]       RST_LEFT_PROP_GAIN   = 16'd635;
    localparam logic [GAIN_W-1:0]       RST_LEFT_INT_GAIN    = 16'd308;
    localparam logic [GAIN_W-1:0]       RST_RIGHT_PROP_GAIN  = 16'd625;
    localparam logic [GAIN_W-1:0]       RST_RIGHT_INT_GAIN   = 16'd308;
    localparam logic [GAIN_W-1:0]       RST_DERIV_GAIN       = 16'd0;
    localparam logic [SCALE_W-1:0]      RST_LEFT_SPEED_SCALE = 10'd312;
    localparam logic [RATE_SCALE_W-1:0] RST_COUNT_RATE_SCALE = 12'd328;
    localparam logic [DUTY_W-1:0]       RST_MIN_DRIVE        = 10'd120;

    typedef struct packed {
        logic               opcode;
        logic [COUNT_W-1:0] left_count;
        logic [COUNT_W-1:0] right_count;
        logic [SP_W-1:0]    left_setpoint;
        logic [SP_W-1:0]    right_setpoint;
    } in_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0]         left_duty;
        logic [DUTY_W-1:0]         right_duty;
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [SPEED_W-1:0] right_speed;
    } result_t;

    typedef struct packed {
        logic [GAIN_W-1:0]       left_prop_gain;
        logic [GAIN_W-1:0]       left_int_gain;
        logic [GAIN_W-1:0]       right_prop_gain;
        logic [GAIN_W-1:0]       right_int_gain;
        logic [GAIN_W-1:0]       deriv_gain;
        logic [SCALE_W-1:0]      left_speed_scale;
        logic [RATE_SCALE_W-1:0] count_rate_scale;
        logic [DUTY_W-1:0]       min_drive;
    } cfg_t;

    // top level to sequencer
    typedef struct packed {
        logic start;
        logic res_ready;
    } seq_ctrl_t;

    // sequencer to top level
    typedef struct packed {
        logic busy;
        logic done;
    } seq_stat_t;

endpackage

@@ hdl/dual_wheel_speed_pid.sv @@
// ----------------------------------------------------------------------------
// dual_wheel_speed_pid
// Two-wheel encoder speed measurement and PID duty controller.
// ----------------------------------------------------------------------------
// A control tick is worked through in turn under a small sequencer: one shared
// 32x17 multiplier forms all nine products of a tick (two rates, the left
// calibration and three gain products per wheel). A stop also yields a result.
// The input stalls while an item is being worked on; a finished result waits in
// the output register, so the next item can be taken while the result is still
// stalled. Configuration registers are written through the cfg channel, always
// ready, and should be changed only while the block is idle.
module dual_wheel_speed_pid
    import dwsp_pkg::*;
#(
    parameter int PWM_TOP   = PWM_TOP_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  in_item_t              item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg_reg;
    seq_ctrl_t ctrl;
    seq_stat_t stat;
    result_t   seq_result;
    logic      result_valid_reg;
    result_t   result_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_prop_gain   <= RST_LEFT_PROP_GAIN;
            cfg_reg.left_int_gain    <= RST_LEFT_INT_GAIN;
            cfg_reg.right_prop_gain  <= RST_RIGHT_PROP_GAIN;
            cfg_reg.right_int_gain   <= RST_RIGHT_INT_GAIN;
            cfg_reg.deriv_gain       <= RST_DERIV_GAIN;
            cfg_reg.left_speed_scale <= RST_LEFT_SPEED_SCALE;
            cfg_reg.count_rate_scale <= RST_COUNT_RATE_SCALE;
            cfg_reg.min_drive        <= RST_MIN_DRIVE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LEFT_PROP_GAIN:   cfg_reg.left_prop_gain   <= cfg_data;
                REG_LEFT_INT_GAIN:    cfg_reg.left_int_gain    <= cfg_data;
                REG_RIGHT_PROP_GAIN:  cfg_reg.right_prop_gain  <= cfg_data;
                REG_RIGHT_INT_GAIN:   cfg_reg.right_int_gain   <= cfg_data;
                REG_DERIV_GAIN:       cfg_reg.deriv_gain       <= cfg_data;
                REG_LEFT_SPEED_SCALE: cfg_reg.left_speed_scale <= cfg_data[SCALE_W-1:0];
                REG_COUNT_RATE_SCALE: cfg_reg.count_rate_scale <= cfg_data[RATE_SCALE_W-1:0];
                REG_MIN_DRIVE:        cfg_reg.min_drive        <= cfg_data[DUTY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // input handshake and sequencer control
    assign item_stall     = stat.busy;
    assign ctrl.start     = item_valid && !item_stall;
    assign ctrl.res_ready = !result_valid_reg || !result_stall;

    dwsp_seq #(
        .PWM_TOP   (PWM_TOP),
        .FRAC_BITS (FRAC_BITS)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .item   (item),
        .cfg    (cfg_reg),
        .stat   (stat),
        .result (seq_result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (stat.done)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
            result_reg <= seq_result;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a finished item never overwrites a result that is still stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> !(result_valid_reg && result_stall))
        else $error("result overwritten while stalled");

    // an accepted item makes the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("block not busy after item transfer");

    // a new result shows up only after the sequencer finished
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(stat.done))
        else $error("result valid without finished item");

endmodule

@@ hdl/dwsp_mul.sv @@
// ----------------------------------------------------------------------------
// dwsp_mul
// Shared signed multiplier with a registered product, one product per cycle.
// ----------------------------------------------------------------------------
module dwsp_mul
    import dwsp_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] prod
);

    logic signed [MUL_P_W-1:0] prod_reg;

    // product register
    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign prod = prod_reg;

endmodule

@@ hdl/dwsp_seq.sv @@
// ----------------------------------------------------------------------------
// dwsp_seq
// Sequencer and datapath: rate, averaging, calibration and both PID loops,
// all products going through one shared multiplier.
// ----------------------------------------------------------------------------
module dwsp_seq
    import dwsp_pkg::*;
#(
    parameter int PWM_TOP   = PWM_TOP_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    input  seq_ctrl_t ctrl,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output seq_stat_t stat,
    output result_t   result
);

    localparam int INT_W = $clog2(PWM_TOP + 1) + FRAC_BITS + 1;
    localparam logic signed [ACC_W-1:0] TOP_FX = ACC_W'(PWM_TOP) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ONE_FX = ACC_W'(1) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] SPD_MAX = ACC_W'((1 << (SPEED_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SPD_MIN = -(ACC_W'(1) << (SPEED_W - 1));

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LINST = 4'd1;
    localparam logic [3:0] S_RINST = 4'd2;
    localparam logic [3:0] S_LSCL  = 4'd3;
    localparam logic [3:0] S_LSAT  = 4'd4;
    localparam logic [3:0] S_ERR   = 4'd5;
    localparam logic [3:0] S_KI    = 4'd6;
    localparam logic [3:0] S_KP    = 4'd7;
    localparam logic [3:0] S_KD    = 4'd8;
    localparam logic [3:0] S_DACC  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    function automatic logic signed [SPEED_W-1:0] sat_speed(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [SPEED_W-1:0] r;
        if (v > SPD_MAX)
            r = SPD_MAX[SPEED_W-1:0];
        else if (v < SPD_MIN)
            r = SPD_MIN[SPEED_W-1:0];
        else
            r = v[SPEED_W-1:0];
        return r;
    endfunction

    logic [3:0] state_reg;
    logic       wheel_reg;

    // controller state per wheel, index 0 left, 1 right
    logic [COUNT_W-1:0]        prev_count_reg [2];
    logic signed [SPEED_W-1:0] prev_rate_reg  [2];
    logic signed [INT_W-1:0]   integ_reg      [2];
    logic signed [SPEED_W-1:0] perr_reg       [2];

    // working registers
    logic [COUNT_W-1:0]        lcnt_reg;
    logic [COUNT_W-1:0]        rcnt_reg;
    logic [SP_W-1:0]           sp_reg   [2];
    logic signed [SPEED_W-1:0] spd_reg  [2];
    logic [DUTY_W-1:0]         duty_reg [2];
    logic signed [SPEED_W-1:0] err_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   prod_sh;

    logic                      rate_wheel;
    logic signed [SPEED_W-1:0] inst;
    logic signed [SPEED_W:0]   rate_sum;
    logic signed [SPEED_W-1:0] avg;

    logic signed [SPEED_W:0]   spd_ext;
    logic signed [SPEED_W:0]   mag;
    logic signed [SPEED_W:0]   err_full;
    logic signed [SPEED_W:0]   err_diff;

    logic [GAIN_W-1:0]         kp_sel;
    logic [GAIN_W-1:0]         ki_sel;
    logic signed [ACC_W-1:0]   isum;
    logic signed [ACC_W-1:0]   iclamp;
    logic signed [ACC_W-1:0]   outc;
    logic signed [ACC_W-1:0]   outsh;
    logic signed [ACC_W-1:0]   sp_fx;
    logic signed [ACC_W-1:0]   mind_fx;
    logic [DUTY_W-1:0]         drive;
    logic [DUTY_W-1:0]         duty_new;

    dwsp_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // product scaling
    assign prod_ext = ACC_W'(prod);
    assign prod_sh  = prod_ext >>> FRAC_BITS;

    // instantaneous rate and two-tap average
    assign rate_wheel = (state_reg == S_LSCL);
    assign inst       = sat_speed(prod_ext);
    assign rate_sum   = (SPEED_W + 1)'(inst) + (SPEED_W + 1)'(prev_rate_reg[rate_wheel]);
    assign avg        = rate_sum[SPEED_W:1];

    // speed error and derivative difference
    assign spd_ext  = (SPEED_W + 1)'(spd_reg[wheel_reg]);
    assign mag      = spd_ext[SPEED_W] ? -spd_ext : spd_ext;
    assign err_full = $signed((SPEED_W + 1)'(sp_reg[wheel_reg])) - mag;
    assign err_diff = (SPEED_W + 1)'(err_reg) - (SPEED_W + 1)'(perr_reg[wheel_reg]);

    // gain selection
    assign kp_sel = wheel_reg ? cfg.right_prop_gain : cfg.left_prop_gain;
    assign ki_sel = wheel_reg ? cfg.right_int_gain  : cfg.left_int_gain;

    // integral update with saturation
    assign isum = ACC_W'(integ_reg[wheel_reg]) + prod_sh;
    always_comb
    begin
        if (isum > TOP_FX)
            iclamp = TOP_FX;
        else if (isum < -TOP_FX)
            iclamp = -TOP_FX;
        else
            iclamp = isum;
    end

    // output clamp and minimum drive
    assign sp_fx   = $signed(ACC_W'(sp_reg[wheel_reg]));
    assign mind_fx = $signed(ACC_W'(cfg.min_drive)) << FRAC_BITS;
    assign drive   = (int'(cfg.min_drive) > PWM_TOP) ? DUTY_W'(PWM_TOP) : cfg.min_drive;
    always_comb
    begin
        if (acc_reg > TOP_FX)
            outc = TOP_FX;
        else if (acc_reg < 0)
            outc = '0;
        else
            outc = acc_reg;
        outsh = outc >>> FRAC_BITS;
        if (sp_fx > ONE_FX && outc > 0 && outc < mind_fx)
            duty_new = drive;
        else
            duty_new = outsh[DUTY_W-1:0];
    end

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_LINST:
            begin
                mul_a = $signed(lcnt_reg - prev_count_reg[0]);
                mul_b = $signed(MUL_B_W'(cfg.count_rate_scale));
            end
            S_RINST:
            begin
                mul_a = $signed(rcnt_reg - prev_count_reg[1]);
                mul_b = $signed(MUL_B_W'(cfg.count_rate_scale));
            end
            S_LSCL:
            begin
                mul_a = MUL_A_W'(spd_reg[0]);
                mul_b = $signed(MUL_B_W'(cfg.left_speed_scale));
            end
            S_KI:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = $signed(MUL_B_W'(ki_sel));
            end
            S_KP:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = $signed(MUL_B_W'(kp_sel));
            end
            S_KD:
            begin
                mul_a = MUL_A_W'(err_diff);
                mul_b = $signed(MUL_B_W'(cfg.deriv_gain));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wheel_reg <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                prev_count_reg[i] <= '0;
                prev_rate_reg[i]  <= '0;
                integ_reg[i]      <= '0;
                perr_reg[i]       <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        if (item.opcode == OP_STOP)
                        begin
                            for (int i = 0; i < 2; i++)
                            begin
                                integ_reg[i] <= '0;
                                perr_reg[i]  <= '0;
                            end
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_LINST;
                        end
                    end
                end
                S_LINST:
                begin
                    state_reg <= S_RINST;
                end
                S_RINST:
                begin
                    prev_count_reg[0] <= lcnt_reg;
                    prev_rate_reg[0]  <= inst;
                    state_reg         <= S_LSCL;
                end
                S_LSCL:
                begin
                    prev_count_reg[1] <= rcnt_reg;
                    prev_rate_reg[1]  <= inst;
                    state_reg         <= S_LSAT;
                end
                S_LSAT:
                begin
                    wheel_reg <= 1'b0;
                    state_reg <= S_ERR;
                end
                S_ERR:
                begin
                    state_reg <= S_KI;
                end
                S_KI:
                begin
                    state_reg <= S_KP;
                end
                S_KP:
                begin
                    if (ki_sel != '0)
                        integ_reg[wheel_reg] <= INT_W'(iclamp);
                    state_reg <= S_KD;
                end
                S_KD:
                begin
                    perr_reg[wheel_reg] <= err_reg;
                    state_reg           <= S_DACC;
                end
                S_DACC:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!wheel_reg)
                    begin
                        wheel_reg <= 1'b1;
                        state_reg <= S_ERR;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (ctrl.res_ready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // working datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctrl.start)
                begin
                    lcnt_reg  <= COUNT_W'(0) - item.left_count;
                    rcnt_reg  <= item.right_count;
                    sp_reg[0] <= item.left_setpoint;
                    sp_reg[1] <= item.right_setpoint;
                    for (int i = 0; i < 2; i++)
                    begin
                        spd_reg[i]  <= '0;
                        duty_reg[i] <= '0;
                    end
                end
            end
            S_RINST:
            begin
                spd_reg[0] <= avg;
            end
            S_LSCL:
            begin
                spd_reg[1] <= avg;
            end
            S_LSAT:
            begin
                spd_reg[0] <= sat_speed(prod_sh);
            end
            S_ERR:
            begin
                err_reg <= err_full[SPEED_W-1:0];
            end
            S_KD:
            begin
                acc_reg <= prod_sh + ACC_W'(integ_reg[wheel_reg]);
            end
            S_DACC:
            begin
                acc_reg <= acc_reg + prod_sh;
            end
            S_FIN:
            begin
                duty_reg[wheel_reg] <= duty_new;
            end
            default:
            begin
            end
        endcase
    end

    // status and result
    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = (state_reg == S_DONE) && ctrl.res_ready;

    assign result.left_duty   = duty_reg[0];
    assign result.right_duty  = duty_reg[1];
    assign result.left_speed  = spd_reg[0];
    assign result.right_speed = spd_reg[1];

endmodule

@@ tb/sv/wheel_pid_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_pid_checker
// Watches the tick, result and register channels of the dual wheel speed
// controller. For every accepted tick it computes the expected duties and
// speeds from its own copy of the registers and controller state, and compares
// each result transfer in order against the oldest expectation.
// ----------------------------------------------------------------------------
module wheel_pid_checker
    import dwsp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_stall,
    input  in_item_t              item,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  result_t               result,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    localparam int     FRAC     = FRAC_BITS_DEF;
    localparam longint DUTY_FS  = longint'(PWM_TOP_DEF) <<< FRAC;
    localparam longint SPEED_HI = (longint'(1) <<< (SPEED_W - 1)) - 1;
    localparam longint SPEED_LO = -(longint'(1) <<< (SPEED_W - 1));
    localparam int     LEFT     = 0;
    localparam int     RIGHT    = 1;

    // register copy and per-wheel controller state
    cfg_t               regs;
    logic [COUNT_W-1:0] prev_count [2];
    longint             prev_rate [2];
    longint             int_term [2];
    longint             prev_err [2];

    // expected duties and speeds, oldest first
    result_t duty_speed_q [$];
    int      mismatches;

    function automatic longint clamp_speed(input longint v);
        longint r;
        r = v;
        if (v > SPEED_HI)
            r = SPEED_HI;
        else if (v < SPEED_LO)
            r = SPEED_LO;
        return r;
    endfunction

    // wrapped count delta to rate, averaged with the last rate
    function automatic longint wheel_rate(input int w, input logic [COUNT_W-1:0] cnt);
        logic [COUNT_W-1:0] d;
        longint             inst;
        longint             avg;
        d    = cnt - prev_count[w];
        inst = clamp_speed(longint'($signed(d)) * longint'(regs.count_rate_scale));
        avg  = (inst + prev_rate[w]) >>> 1;
        prev_count[w] = cnt;
        prev_rate[w]  = inst;
        return avg;
    endfunction

    // pid with saturating integral, output clamp and minimum drive
    function automatic logic [DUTY_W-1:0] wheel_duty(input int w, input longint speed,
                                                     input logic [SP_W-1:0] sp,
                                                     input logic [GAIN_W-1:0] kp,
                                                     input logic [GAIN_W-1:0] ki);
        longint            mag;
        longint            err;
        longint            out_q;
        logic [DUTY_W-1:0] duty;
        mag = (speed < 0) ? -speed : speed;
        err = longint'(sp) - mag;
        // integral only moves, and is only re-clamped, with a nonzero gain
        if (ki != '0)
        begin
            int_term[w] += (err * longint'(ki)) >>> FRAC;
            if (int_term[w] > DUTY_FS)
                int_term[w] = DUTY_FS;
            else if (int_term[w] < -DUTY_FS)
                int_term[w] = -DUTY_FS;
        end
        out_q = ((err * longint'(kp)) >>> FRAC) + int_term[w]
              + (((err - prev_err[w]) * longint'(regs.deriv_gain)) >>> FRAC);
        prev_err[w] = err;
        if (out_q > DUTY_FS)
            out_q = DUTY_FS;
        else if (out_q < 0)
            out_q = 0;
        duty = DUTY_W'(out_q >>> FRAC);
        // small positive drive is raised while the setpoint is above 1 rpm
        if (longint'(sp) > (longint'(1) <<< FRAC) && out_q > 0
            && out_q < (longint'(regs.min_drive) <<< FRAC))
            duty = (regs.min_drive > PWM_TOP_DEF) ? DUTY_W'(PWM_TOP_DEF) : regs.min_drive;
        return duty;
    endfunction

    function automatic result_t predict_duties(input in_item_t pkt);
        result_t            r;
        longint             ls;
        longint             rs;
        logic [COUNT_W-1:0] left_neg;
        r = '0;
        if (pkt.opcode == OP_STOP)
        begin
            // stop clears integrals and last errors, counters and rates stay
            for (int w = 0; w < 2; w++)
            begin
                int_term[w] = 0;
                prev_err[w] = 0;
            end
        end
        else
        begin
            left_neg = ~pkt.left_count + COUNT_W'(1);
            ls = wheel_rate(LEFT, left_neg);
            rs = wheel_rate(RIGHT, pkt.right_count);
            ls = clamp_speed((ls * longint'(regs.left_speed_scale)) >>> FRAC);
            r.left_duty   = wheel_duty(LEFT, ls, pkt.left_setpoint,
                                       regs.left_prop_gain, regs.left_int_gain);
            r.right_duty  = wheel_duty(RIGHT, rs, pkt.right_setpoint,
                                       regs.right_prop_gain, regs.right_int_gain);
            r.left_speed  = ls[SPEED_W-1:0];
            r.right_speed = rs[SPEED_W-1:0];
        end
        return r;
    endfunction

    function automatic int check_field(input string name, input logic signed [63:0] want_v,
                                       input logic signed [63:0] got_v);
        int bad;
        bad = 0;
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            bad = 1;
        end
        return bad;
    endfunction

    // channel monitor: register writes, result transfers, tick transfers
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            regs.left_prop_gain   = RST_LEFT_PROP_GAIN;
            regs.left_int_gain    = RST_LEFT_INT_GAIN;
            regs.right_prop_gain  = RST_RIGHT_PROP_GAIN;
            regs.right_int_gain   = RST_RIGHT_INT_GAIN;
            regs.deriv_gain       = RST_DERIV_GAIN;
            regs.left_speed_scale = RST_LEFT_SPEED_SCALE;
            regs.count_rate_scale = RST_COUNT_RATE_SCALE;
            regs.min_drive        = RST_MIN_DRIVE;
            for (int w = 0; w < 2; w++)
            begin
                prev_count[w] = '0;
                prev_rate[w]  = 0;
                int_term[w]   = 0;
                prev_err[w]   = 0;
            end
            duty_speed_q.delete();
            mismatches = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LEFT_PROP_GAIN:   regs.left_prop_gain   = cfg_data[GAIN_W-1:0];
                    REG_LEFT_INT_GAIN:    regs.left_int_gain    = cfg_data[GAIN_W-1:0];
                    REG_RIGHT_PROP_GAIN:  regs.right_prop_gain  = cfg_data[GAIN_W-1:0];
                    REG_RIGHT_INT_GAIN:   regs.right_int_gain   = cfg_data[GAIN_W-1:0];
                    REG_DERIV_GAIN:       regs.deriv_gain       = cfg_data[GAIN_W-1:0];
                    REG_LEFT_SPEED_SCALE: regs.left_speed_scale = cfg_data[SCALE_W-1:0];
                    REG_COUNT_RATE_SCALE: regs.count_rate_scale = cfg_data[RATE_SCALE_W-1:0];
                    REG_MIN_DRIVE:        regs.min_drive        = cfg_data[DUTY_W-1:0];
                    default: ;
                endcase
            end

            if (result_valid && !result_stall)
            begin
                if (duty_speed_q.size() == 0)
                begin
                    $display("%0t: unexpected result transfer, expected none, got %h",
                             $time, result);
                    mismatches++;
                end
                else
                begin
                    want = duty_speed_q.pop_front();
                    mismatches += check_field("left_duty", want.left_duty, result.left_duty);
                    mismatches += check_field("right_duty", want.right_duty, result.right_duty);
                    mismatches += check_field("left_speed", want.left_speed, result.left_speed);
                    mismatches += check_field("right_speed", want.right_speed,
                                              result.right_speed);
                end
            end

            if (item_valid && !item_stall)
                duty_speed_q.push_back(predict_duties(item));

            errors  <= mismatches;
            pending <= duty_speed_q.size();
        end
    end

endmodule

@@ tb/sv/dual_wheel_speed_pid_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_wheel_speed_pid_tb
// Drives control ticks and stops into the dual wheel speed controller under
// several register settings and idle/stall mixes, including a long output
// hold-off. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module dual_wheel_speed_pid_tb;
    import dwsp_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 24;
    localparam int TIMEOUT_NS   = 3000000;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    in_item_t              item         = '0;
    logic                  result_stall = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  item_stall;
    logic                  result_valid;
    result_t               result;
    logic                  cfg_ready;
    int                    errors;
    int                    pending;

    // stimulus control and bookkeeping
    int                 idle_pct      = 0;
    int                 stall_pct     = 0;
    int                 hold_reqs     = 0;
    int                 ticks_sent    = 0;
    int                 stops_sent    = 0;
    int                 settings_used = 1;
    logic [COUNT_W-1:0] left_raw      = '0;
    logic [COUNT_W-1:0] right_raw     = '0;

    dual_wheel_speed_pid u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    wheel_pid_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // result side: random stalls, or a long hold-off when requested
    initial
    begin
        int hold_seen;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic set_idling(input int snd, input int rcv);
        idle_pct = snd;
        stall_pct <= rcv;
    endtask

    // one tick transfer with optional idle gaps in front
    task automatic send_item(input in_item_t pkt);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= pkt;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        if (pkt.opcode == OP_TICK)
        begin
            ticks_sent++;
            left_raw  = pkt.left_count;
            right_raw = pkt.right_count;
        end
        else
            stops_sent++;
    endtask

    task automatic send_tick(input logic op, input logic [COUNT_W-1:0] lc,
                             input logic [COUNT_W-1:0] rc, input logic [SP_W-1:0] lsp,
                             input logic [SP_W-1:0] rsp);
        in_item_t pkt;
        pkt.opcode         = op;
        pkt.left_count     = lc;
        pkt.right_count    = rc;
        pkt.left_setpoint  = lsp;
        pkt.right_setpoint = rsp;
        send_item(pkt);
    endtask

    function automatic logic [SP_W-1:0] pick_setpoint();
        int sel;
        logic [SP_W-1:0] sp;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            sp = SP_W'($urandom_range(0, 40000));
        else if (sel < 90)
            sp = SP_W'($urandom_range(0, 600));
        else
            sp = SP_W'($urandom);
        return sp;
    endfunction

    function automatic logic [COUNT_W-1:0] step_count(input logic [COUNT_W-1:0] c);
        int d;
        d = int'($urandom_range(0, 400)) - 200;
        return c + COUNT_W'(d);
    endfunction

    // mostly plausible encoder motion, some stops, jumps and pure noise
    task automatic send_random(input int n);
        in_item_t pkt;
        int       kind;
        repeat (n)
        begin
            kind = $urandom_range(0, 99);
            pkt.opcode         = OP_TICK;
            pkt.left_count     = step_count(left_raw);
            pkt.right_count    = step_count(right_raw);
            pkt.left_setpoint  = pick_setpoint();
            pkt.right_setpoint = pick_setpoint();
            if (kind < 8)
            begin
                pkt.opcode      = OP_STOP;
                pkt.left_count  = $urandom;
                pkt.right_count = $urandom;
            end
            else if (kind < 18)
            begin
                pkt.left_count     = $urandom;
                pkt.right_count    = $urandom;
                pkt.left_setpoint  = SP_W'($urandom);
                pkt.right_setpoint = SP_W'($urandom);
            end
            else if (kind < 23)
            begin
                pkt.left_count  = left_raw + $urandom_range(0, 1 << 20);
                pkt.right_count = right_raw - $urandom_range(0, 1 << 20);
            end
            send_item(pkt);
        end
    endtask

    // stop offering ticks and let every expected result come out
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [15:0] lp, input logic [15:0] li,
                                 input logic [15:0] rp, input logic [15:0] ri,
                                 input logic [15:0] kd, input logic [15:0] ss,
                                 input logic [15:0] rs, input logic [15:0] md);
        write_reg(REG_LEFT_PROP_GAIN, lp);
        write_reg(REG_LEFT_INT_GAIN, li);
        write_reg(REG_RIGHT_PROP_GAIN, rp);
        write_reg(REG_RIGHT_INT_GAIN, ri);
        write_reg(REG_DERIV_GAIN, kd);
        write_reg(REG_LEFT_SPEED_SCALE, ss);
        write_reg(REG_COUNT_RATE_SCALE, rs);
        write_reg(REG_MIN_DRIVE, md);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic apply_random_setting();
        apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom_range(0, 2000)), 16'($urandom_range(0, 1023)),
                      16'($urandom_range(0, 4095)), 16'($urandom_range(0, 999)));
    endtask

    // main sequence
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed ticks under reset settings, back to back
        set_idling(0, 0);
        send_tick(OP_TICK, 32'd0, 32'd0, 16'd0, 16'd0);
        send_tick(OP_TICK, 32'd50, 32'd60, 16'd300, 16'd300);
        send_tick(OP_TICK, 32'd100, 32'd120, 16'd256, 16'd256);
        send_tick(OP_TICK, 32'd150, 32'd180, 16'd257, 16'd0);
        repeat (3) send_tick(OP_TICK, 32'd150, 32'd180, 16'hFFFF, 16'hFFFF);
        send_tick(OP_STOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_tick(OP_TICK, 32'h8000_0000, 32'h7FFF_FFFF, 16'd20000, 16'd20000);
        send_tick(OP_TICK, 32'h7FFF_FFFF, 32'h8000_0000, 16'd20000, 16'd20000);
        send_tick(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd5000, 16'd5000);
        send_tick(OP_TICK, 32'h0000_0010, 32'h0000_0010, 16'd5000, 16'd5000);
        send_tick(OP_TICK, 32'h8000_0010, 32'h8000_0010, 16'd5000, 16'd5000);
        send_tick(OP_TICK, 32'h8000_0010, 32'h8000_0010, 16'd0, 16'd0);
        send_tick(OP_STOP, 32'd0, 32'd0, 16'd0, 16'd0);
        send_tick(OP_TICK, 32'h8000_0020, 32'h8000_0030, 16'd1000, 16'd1000);
        send_tick(OP_TICK, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, 16'd0);
        send_tick(OP_TICK, 32'd0, 32'hFFFF_FFFF, 16'd0, 16'hFFFF);
        send_tick(OP_TICK, 32'd40, 32'd40, 16'd400, 16'd400);

        set_idling(53, 0);
        send_random(100);

        // random settings, receiver stalls
        drain();
        apply_random_setting();
        set_idling(0, 53);
        send_random(150);

        // long result hold-off while ticks keep coming, then a full pause
        hold_reqs <= hold_reqs + 1;
        set_idling(0, 0);
        send_random(12);
        drain();

        // every register at its top value but the minimum drive, set to 999
        apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'd1023, 16'd4095, 16'd999);
        set_idling(38, 38);
        send_random(120);

        // every register zero: integral gains off, no minimum drive
        drain();
        apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        set_idling(0, 0);
        send_random(100);

        // near reset settings with a derivative term
        drain();
        apply_setting(16'd635, 16'd308, 16'd625, 16'd308, 16'd200,
                      16'd312, 16'd328, 16'd120);
        set_idling(53, 0);
        send_random(75);
        set_idling(0, 53);
        send_random(75);

        drain();
        apply_random_setting();
        set_idling(38, 38);
        send_random(100);

        drain();
        $display("Covered %0d ticks and %0d stops over %0d register settings,",
                 ticks_sent, stops_sent, settings_used);
        $display("with idle/stall mixes and a %0d-cycle result hold-off", HOLD_CYCLES);
        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout after %0d ns with %0d results outstanding", TIMEOUT_NS, pending);
        $display("Verification failed");
        $finish;
    end

endmodule
